@@ hw/rtl/nec_ir_pkg.sv @@
`timescale 1ns / 1ps
// Package for the NEC infrared pulse decoder: field widths, window bounds in
// eighths of a millisecond and the default tick rate.
// No dependencies; used by nec_ir_pulse_decoder_unit.
package nec_ir_pkg;

    localparam int TICKS_PER_MS_DEFAULT = 40000;

    localparam int TICKS_W = 32;
    localparam int CODE_W  = 16;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;
    // Interval scaled to eighths of a millisecond: three more bits.
    localparam int T8_W    = TICKS_W + 3;

    // Window bounds, in eighths of a millisecond, all strict.
    localparam int REP_LO   = 89;
    localparam int REP_HI   = 91;
    localparam int START_LO = 106;
    localparam int START_HI = 110;
    localparam int ZERO_LO  = 8;
    localparam int ZERO_HI  = 10;
    localparam int ONE_LO   = 17;
    localparam int ONE_HI   = 19;

    // Bit index codes.
    localparam logic [INDEX_W-1:0] IDX_IDLE  = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] IDX_FIRST = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] IDX_LAST  = INDEX_W'(32);
    localparam logic [INDEX_W-1:0] IDX_DONE  = INDEX_W'(33);

    // Item kinds carried on the action field.
    localparam logic ACT_INTERVAL = 1'b0;
    localparam logic ACT_ACK      = 1'b1;

endpackage

@@ hw/rtl/nec_ir_pulse_decoder_unit.sv @@
`timescale 1ns / 1ps
// Top level of the NEC infrared pulse decoder: input register, window
// compares, frame state and result register in one module.
// Depends on nec_ir_pkg.
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------------
//  input     in         in_valid / in_stall     action, interval_ticks, repeat_code
//  output    out        out_valid / out_stall   command_code, is_repeat
//
// One item is taken per clock cycle while in_stall is low. An accepted
// transfer lands in the input register; it is decoded against the state
// and any result is written to the output register when the item moves on
// (output register free or draining); the decode step sets the rate.
// The reset (rst_n, asynchronous, active low) empties both registers and
// returns the decoder to idle with no acknowledge pending. While the output
// register holds a result that is stalled, the item in the input register
// waits, and in_stall is raised only then.
module nec_ir_pulse_decoder_unit
    import nec_ir_pkg::*;
#(
    parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [TICKS_W-1:0] interval_ticks,
    input  logic [CODE_W-1:0]  repeat_code,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [CODE_W-1:0]  command_code,
    output logic               is_repeat
);

    // Window bounds in ticks times eight. Every product fits well inside 32
    // bits at the default tick rate, so they are exact.
    localparam logic [T8_W-1:0] REP_LO_T8   = T8_W'(REP_LO   * TICKS_PER_MS);
    localparam logic [T8_W-1:0] REP_HI_T8   = T8_W'(REP_HI   * TICKS_PER_MS);
    localparam logic [T8_W-1:0] START_LO_T8 = T8_W'(START_LO * TICKS_PER_MS);
    localparam logic [T8_W-1:0] START_HI_T8 = T8_W'(START_HI * TICKS_PER_MS);
    localparam logic [T8_W-1:0] ZERO_LO_T8  = T8_W'(ZERO_LO  * TICKS_PER_MS);
    localparam logic [T8_W-1:0] ZERO_HI_T8  = T8_W'(ZERO_HI  * TICKS_PER_MS);
    localparam logic [T8_W-1:0] ONE_LO_T8   = T8_W'(ONE_LO   * TICKS_PER_MS);
    localparam logic [T8_W-1:0] ONE_HI_T8   = T8_W'(ONE_HI   * TICKS_PER_MS);

    // Input register.
    logic               in_full_reg;
    logic               action_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [CODE_W-1:0]  code_reg;

    // Decoder state.
    logic [INDEX_W-1:0] bit_index_reg, bit_index_next;
    logic [WORD_W-1:0]  shift_word_reg, shift_word_next;
    logic               ack_reg, ack_next;
    logic [CODE_W-1:0]  held_code_reg, held_code_next;

    // Output register.
    logic               out_full_reg;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               out_rep_reg, out_rep_next;

    logic               emit;
    logic               advance;
    logic               in_fire;
    logic [T8_W-1:0]    t8;
    logic               win_rep, win_start, win_zero, win_one;
    logic               rep_hit;
    logic [4:0]         bit_pos;

    // The held item moves on when the output register is free or being
    // drained in this cycle; a new transfer is taken whenever the input
    // register is empty or its item is moving on.
    assign advance  = !out_full_reg || !out_stall;
    assign in_stall = in_full_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    assign t8        = {ticks_reg, 3'b000};
    assign win_rep   = (t8 > REP_LO_T8)   && (t8 < REP_HI_T8);
    assign win_start = (t8 > START_LO_T8) && (t8 < START_HI_T8);
    assign win_zero  = (t8 > ZERO_LO_T8)  && (t8 < ZERO_HI_T8);
    assign win_one   = (t8 > ONE_LO_T8)   && (t8 < ONE_HI_T8);
    assign rep_hit   = ack_reg && win_rep;
    assign bit_pos   = 5'(bit_index_reg - IDX_FIRST);

    // Decode of the item in the input register.
    always_comb
    begin
        bit_index_next  = bit_index_reg;
        shift_word_next = shift_word_reg;
        ack_next        = ack_reg;
        held_code_next  = held_code_reg;
        emit            = 1'b0;
        out_code_next   = held_code_reg;
        out_rep_next    = 1'b1;

        if (action_reg == ACT_ACK)
        begin
            ack_next       = 1'b1;
            held_code_next = code_reg;
        end
        else
        begin
            if (rep_hit)
            begin
                // A repeat frame reissues the acknowledged code once.
                emit     = 1'b1;
                ack_next = 1'b0;
            end
            else if (win_start)
            begin
                bit_index_next = IDX_FIRST;
            end
            else if (bit_index_reg >= IDX_FIRST && bit_index_reg <= IDX_LAST)
            begin
                if (win_zero)
                begin
                    shift_word_next[bit_pos] = 1'b0;
                    bit_index_next           = bit_index_reg + INDEX_W'(1);
                end
                else if (win_one)
                begin
                    shift_word_next[bit_pos] = 1'b1;
                    bit_index_next           = bit_index_reg + INDEX_W'(1);
                end
            end

            // Once the word is complete, every interval shifts it down by
            // half a word, so the command is reported at most once and then drains.
            if (bit_index_next == IDX_DONE)
            begin
                shift_word_next = shift_word_next >> (WORD_W / 2);
                if (shift_word_next != '0 && !rep_hit)
                begin
                    emit          = 1'b1;
                    out_code_next = shift_word_next[CODE_W-1:0];
                    out_rep_next  = 1'b0;
                    ack_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            out_full_reg   <= 1'b0;
            bit_index_reg  <= IDX_IDLE;
            shift_word_reg <= '0;
            ack_reg        <= 1'b0;
            held_code_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (in_full_reg && advance)
            begin
                bit_index_reg  <= bit_index_next;
                shift_word_reg <= shift_word_next;
                ack_reg        <= ack_next;
                held_code_reg  <= held_code_next;
            end

            if (advance)
            begin
                out_full_reg <= in_full_reg && emit;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            ticks_reg  <= interval_ticks;
            code_reg   <= repeat_code;
        end
        if (in_full_reg && advance && emit)
        begin
            out_code_reg <= out_code_next;
            out_rep_reg  <= out_rep_next;
        end
    end

    assign out_valid    = out_full_reg;
    assign command_code = out_code_reg;
    assign is_repeat    = out_rep_reg;

    // The bit index never runs past the completed-word code.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= IDX_DONE)
        else $error("bit index beyond completed word");

    // Any emitted result clears a pending acknowledge.
    a_emit_clears_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && advance && emit) |=> !ack_reg)
        else $error("acknowledge still pending after a result");

    // An acknowledge item always leaves one pending and produces nothing.
    a_ack_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && advance && action_reg == ACT_ACK) |=> (ack_reg && !out_full_reg))
        else $error("acknowledge item not recorded or produced a result");

    // The input side only holds off while an item is waiting inside.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_full_reg))
        else $error("input stalled with no item waiting");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nec_ir_pulse_decoder_unit. A local decoder model
// predicts every command and repeat code, which a monitor checks in order.
// Depends on nec_ir_pkg and the decoder RTL only; it reads no files.
module tb;
    import nec_ir_pkg::*;

    // Ticks per millisecond, as the unit is built with its default.
    localparam int unsigned TPM            = TICKS_PER_MS_DEFAULT;
    localparam int unsigned IDLE_PERCENT   = 22;
    localparam int unsigned MAX_GAP        = 6;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned FRAME_COUNT    = 24;
    localparam int unsigned QUIET_FRAMES   = 4;
    localparam int unsigned NOISE_ITEMS    = 250;

    // The four interval windows, and the places where a window ends.
    typedef enum int unsigned {WIN_REPEAT, WIN_START, WIN_ZERO, WIN_ONE} band_t;
    typedef enum int unsigned {EDGE_LO_OUT, EDGE_LO_IN, EDGE_HI_IN, EDGE_HI_OUT} edge_t;

    // One decoded result as the unit should present it.
    typedef struct packed
    {
        logic [CODE_W-1:0] code;
        logic              rep;
    } decoded_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [TICKS_W-1:0] interval_ticks;
    logic [CODE_W-1:0]  repeat_code;
    logic               out_valid;
    logic               out_stall;
    logic [CODE_W-1:0]  command_code;
    logic               is_repeat;

    // Decoder model state, starting from its reset values.
    logic [INDEX_W-1:0] model_index = IDX_IDLE;
    logic [WORD_W-1:0]  model_word  = '0;
    logic               model_acked = 1'b0;
    logic [CODE_W-1:0]  model_held  = '0;

    // Results predicted but not yet seen on the output, oldest first.
    decoded_t pending_commands[$];
    decoded_t oldest_command;

    // Shared between the stimulus, the stall driver and the monitor.
    bit          quiet        = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned error_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned commands_checked = 0;
    int unsigned repeats_checked  = 0;

    nec_ir_pulse_decoder_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .interval_ticks (interval_ticks),
        .repeat_code    (repeat_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .command_code   (command_code),
        .is_repeat      (is_repeat)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Window arithmetic. The bounds are in eighths of a millisecond, so the
    // interval is scaled by eight and compared with bound times TPM. Every
    // product fits comfortably in 64 bits.
    // ------------------------------------------------------------------
    function automatic int unsigned band_lo(band_t w);
        case (w)
            WIN_REPEAT: return REP_LO;
            WIN_START:  return START_LO;
            WIN_ZERO:   return ZERO_LO;
            default:    return ONE_LO;
        endcase
    endfunction

    function automatic int unsigned band_hi(band_t w);
        case (w)
            WIN_REPEAT: return REP_HI;
            WIN_START:  return START_HI;
            WIN_ZERO:   return ZERO_HI;
            default:    return ONE_HI;
        endcase
    endfunction

    function automatic bit in_band(logic [TICKS_W-1:0] ticks, band_t w);
        longint unsigned t8;
        longint unsigned tpm;
        t8  = {29'b0, ticks, 3'b000};
        tpm = TPM;
        return t8 > band_lo(w) * tpm && t8 < band_hi(w) * tpm;
    endfunction

    // A random interval strictly inside a window.
    function automatic logic [TICKS_W-1:0] band_ticks(band_t w);
        return $urandom_range((band_hi(w) * TPM - 1) / 8, band_lo(w) * TPM / 8 + 1);
    endfunction

    // Last tick out, first tick in at the low end; the reverse at the high end.
    function automatic logic [TICKS_W-1:0] band_edge(band_t w, edge_t e);
        case (e)
            EDGE_LO_OUT: return band_lo(w) * TPM / 8;
            EDGE_LO_IN:  return band_lo(w) * TPM / 8 + 1;
            EDGE_HI_IN:  return (band_hi(w) * TPM - 1) / 8;
            default:     return (band_hi(w) * TPM + 7) / 8;
        endcase
    endfunction

    // Intervals of every sort: any 32-bit value, window interiors and ends,
    // and plausible short and long gaps between edges.
    function automatic logic [TICKS_W-1:0] random_ticks();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return band_edge(band_t'($urandom_range(3)), edge_t'($urandom_range(3)));
            2, 3:    return band_ticks(band_t'($urandom_range(3)));
            4:       return $urandom_range(3 * TPM);
            default: return $urandom_range(15 * TPM);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Decoder model. An acknowledge arms a repeat; an interval may fire the
    // repeat, restart the frame or add one data bit. Once the index reaches
    // the complete mark, every interval shifts the word down by sixteen and a
    // nonzero upper half is reported, unless a repeat was reported already.
    // ------------------------------------------------------------------
    task automatic decode_item(logic act, logic [TICKS_W-1:0] ticks, logic [CODE_W-1:0] code);
        bit emitted = 1'b0;
        if (act == ACT_ACK)
        begin
            model_acked = 1'b1;
            model_held  = code;
            return;
        end
        if (model_acked && in_band(ticks, WIN_REPEAT))
        begin
            pending_commands.push_back('{code: model_held, rep: 1'b1});
            emitted     = 1'b1;
            model_acked = 1'b0;
        end
        else if (in_band(ticks, WIN_START))
        begin
            model_index = IDX_FIRST;
        end
        else if (model_index >= IDX_FIRST && model_index <= IDX_LAST)
        begin
            if (in_band(ticks, WIN_ZERO))
            begin
                model_word[model_index - IDX_FIRST] = 1'b0;
                model_index++;
            end
            else if (in_band(ticks, WIN_ONE))
            begin
                model_word[model_index - IDX_FIRST] = 1'b1;
                model_index++;
            end
        end
        if (model_index == IDX_DONE)
        begin
            model_word = model_word >> 16;
            if (model_word != '0 && !emitted)
            begin
                pending_commands.push_back('{code: model_word[CODE_W-1:0], rep: 1'b0});
                model_acked = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. Valid is raised for an item and left high into the next
    // one unless a random gap is taken first, so valid is never dropped and
    // raised in the same time step. The item is accepted at the first edge
    // at which the unit is not stalling.
    // ------------------------------------------------------------------
    task automatic send_item(logic act, logic [TICKS_W-1:0] ticks, logic [CODE_W-1:0] code);
        if (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        interval_ticks <= ticks;
        repeat_code    <= code;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        decode_item(act, ticks, code);
    endtask

    // The field that an item does not use is still random, so that it is
    // seen to be ignored.
    task automatic send_interval(logic [TICKS_W-1:0] ticks);
        send_item(ACT_INTERVAL, ticks, CODE_W'($urandom));
    endtask

    task automatic send_ack(logic [CODE_W-1:0] code);
        send_item(ACT_ACK, $urandom, code);
    endtask

    // A start mark and 32 data bits, least significant first. With noise,
    // acknowledges and intervals below or above every window are slipped in
    // between bits; none of them disturbs the frame.
    task automatic send_frame(logic [WORD_W-1:0] word, bit noisy);
        send_interval(band_ticks(WIN_START));
        for (int i = 0; i < WORD_W; i++)
        begin
            if (noisy && $urandom_range(99) < 8)
            begin
                case ($urandom_range(2))
                    0:       send_ack(CODE_W'($urandom));
                    1:       send_interval($urandom_range(ZERO_LO * TPM / 8));
                    default: send_interval($urandom_range(32'hFFFF_FFFF, START_HI * TPM / 8 + 1));
                endcase
            end
            send_interval(word[i] ? band_ticks(WIN_ONE) : band_ticks(WIN_ZERO));
        end
        frames_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes, the exact ends of each window and the special cases:
    // a repeat without acknowledge, a repeat with one, data bits while idle,
    // a restart in mid-frame and a repeat that falls inside a frame.
    task automatic test_directed();
        send_interval('0);
        send_interval('1);
        send_interval(band_edge(WIN_REPEAT, EDGE_LO_IN));
        send_ack('1);
        send_interval(band_edge(WIN_REPEAT, EDGE_LO_OUT));
        send_interval(band_edge(WIN_REPEAT, EDGE_HI_OUT));
        send_interval(band_edge(WIN_REPEAT, EDGE_HI_IN));
        send_interval(band_edge(WIN_REPEAT, EDGE_HI_IN));
        send_ack('0);
        send_interval(band_edge(WIN_REPEAT, EDGE_LO_IN));
        send_interval(band_edge(WIN_ZERO, EDGE_LO_IN));
        send_interval(band_edge(WIN_ONE, EDGE_HI_IN));
        send_interval(band_edge(WIN_START, EDGE_LO_IN));
        send_interval(band_edge(WIN_ZERO, EDGE_HI_OUT));
        send_interval(band_edge(WIN_ONE, EDGE_LO_IN));
        send_interval(band_edge(WIN_ZERO, EDGE_LO_IN));
        send_interval(band_edge(WIN_START, EDGE_HI_IN));
        send_interval(band_edge(WIN_ONE, EDGE_LO_OUT));
        send_interval(band_edge(WIN_START, EDGE_HI_OUT));
        send_interval(band_edge(WIN_START, EDGE_LO_OUT));
        send_ack(CODE_W'($urandom));
        send_interval(band_ticks(WIN_REPEAT));
        send_interval(band_edge(WIN_ONE, EDGE_HI_IN));
        send_interval(band_edge(WIN_ZERO, EDGE_HI_IN));
    endtask

    // Whole frames with random content, some with a zero upper half, each
    // followed by up to three repeats, with or without an acknowledge, and at
    // times a random interval; these shift the finished word away. The first
    // few run with neither side idling.
    task automatic test_frames();
        logic [WORD_W-1:0] word;
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            quiet = (f < QUIET_FRAMES);
            word  = $urandom;
            if ($urandom_range(7) == 0)
                word[WORD_W-1:16] = '0;
            send_frame(word, f >= QUIET_FRAMES);
            if ($urandom_range(1))
                send_ack(CODE_W'($urandom));
            repeat ($urandom_range(3)) send_interval(band_ticks(WIN_REPEAT));
            if ($urandom_range(3) == 0)
                send_interval(random_ticks());
        end
        quiet = 1'b0;
    endtask

    // The output is held off for a long stretch while acknowledge and repeat
    // pairs keep coming, so both registers fill and the input stalls.
    task automatic test_pressure();
        hold_request = 1'b1;
        for (int k = 0; k < 10; k++)
        begin
            send_ack(CODE_W'($urandom));
            send_interval(band_ticks(WIN_REPEAT));
        end
        send_frame($urandom, 1'b0);
    endtask

    // Mostly random intervals and acknowledges, with broken frames mixed in.
    task automatic test_noise();
        repeat (NOISE_ITEMS)
        begin
            case ($urandom_range(9))
                0, 1:
                    send_ack(CODE_W'($urandom));
                2:
                begin
                    send_interval(band_ticks(WIN_START));
                    repeat ($urandom_range(12))
                        send_interval(band_ticks($urandom_range(1) ? WIN_ONE : WIN_ZERO));
                end
                default:
                    send_interval(random_ticks());
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: the stall driver and the result monitor.
    // ------------------------------------------------------------------

    // Random stalls at a chance of 22 percent, none while quiet, and a long
    // unbroken hold-off when one is requested.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet || $urandom_range(99) >= IDLE_PERCENT)
                out_stall <= 1'b0;
            else
                out_stall <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s, got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Each output transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (pending_commands.size() == 0)
                report_mismatch("result with nothing predicted", 32'(command_code), '0);
            else
            begin
                oldest_command = pending_commands.pop_front();
                if (command_code !== oldest_command.code)
                    report_mismatch("command_code", 32'(command_code),
                                    32'(oldest_command.code));
                if (is_repeat !== oldest_command.rep)
                    report_mismatch("is_repeat", 32'(is_repeat), 32'(oldest_command.rep));
                if (oldest_command.rep)
                    repeats_checked++;
                else
                    commands_checked++;
            end
        end
    end

    // The run is abandoned when no transfer happens on either side for too
    // long; the hold-off above is well inside the limit.
    initial
    begin : watchdog
        int unsigned stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, the tests in turn, then draining of the output.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_INTERVAL;
        interval_ticks <= '0;
        repeat_code    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_frames();
        test_pressure();
        test_noise();

        in_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        // Anything the unit emits beyond the predictions shows up here.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items, %0d of them in %0d complete frames or more.",
                 items_sent, frames_sent * (WORD_W + 1), frames_sent);
        $display("Checked %0d new commands and %0d repeat codes; %0d mismatches.",
                 commands_checked, repeats_checked, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
